/* src/tilt_pkg.sv */
// shared widths, constants and types for the tilt angle pipeline
package tilt_pkg;

	localparam int ROOT_W = 32;
	localparam int REM_W  = 34;
	localparam int CRD_W  = 36;
	localparam int ANG_W  = 32;
	localparam int ITER   = 24;
	localparam int OUT_W  = 15;

	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [CRD_W-1:0] crd_t;

	// atan(2^-i) in radians, 30 fraction bits, truncated
	localparam ang_t ATAN_TAB [ITER] = '{
		32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
		32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
		32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
		32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
		32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
		32'sd1023,      32'sd511,       32'sd255,       32'sd127
	};

	// 18000/pi at 19 fraction bits
	localparam logic [31:0] SCALE_C = 32'd3003948965;
	localparam logic [OUT_W-1:0] RIGHT_ANGLE = 15'd9000;

	typedef struct packed {
		logic zero_x;
		logic zero_m;
		logic neg_x;
	} tilt_flag_t;

endpackage

/* src/accel_tilt_angle.sv */
// top level of the accelerometer tilt angle pipeline
// Takes one sample word per clock, unless in_stall is high, and gives
// atan2(x, sqrt(y*y + z*z)) in signed hundredths of a degree, rounded to
// nearest and clamped to +-9000. Every word passes through a square and sum
// of y and z, 32 square root stages (one root bit each), 24 cordic rotation
// stages and a final scale, round and clamp. A stall on the output freezes the
// whole pipeline at once, so the input is stalled only while a result is held.
module accel_tilt_angle (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [15:0]                accel_x,
	input  logic signed [15:0]                accel_y,
	input  logic signed [15:0]                accel_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tilt_pkg::OUT_W-1:0] tilt_hundredths
);
	import tilt_pkg::*;

	logic                en;
	logic                sq_valid;
	logic [ROOT_W-1:0]   sq_root;
	logic signed [15:0]  sq_x;
	logic                crd_valid;
	ang_t                crd_ang;
	tilt_flag_t          crd_flag;

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	tilt_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.x         (accel_x),
		.y         (accel_y),
		.z         (accel_z),
		.out_valid (sq_valid),
		.root      (sq_root),
		.x_out     (sq_x)
	);

	tilt_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.x         (sq_x),
		.out_valid (crd_valid),
		.ang       (crd_ang),
		.flag      (crd_flag)
	);

	tilt_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (crd_valid),
		.ang       (crd_ang),
		.flag      (crd_flag),
		.out_valid (out_valid),
		.tilt      (tilt_hundredths)
	);

endmodule

/* src/tilt_sqrt.sv */
// squares and sum of the y and z axes, then a one-bit-per-stage square root
module tilt_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [15:0]          x,
	input  logic signed [15:0]          y,
	input  logic signed [15:0]          z,
	output logic                        out_valid,
	output logic [tilt_pkg::ROOT_W-1:0] root,
	output logic signed [15:0]          x_out
);
	import tilt_pkg::*;

	logic signed [31:0] ysq;
	logic signed [31:0] zsq;
	logic               v_s1;
	logic [31:0]        ysq_s1;
	logic [31:0]        zsq_s1;
	logic signed [15:0] x_s1;
	logic               v_s2;
	logic [31:0]        sq_s2;
	logic signed [15:0] x_s2;

	logic               v_s    [ROOT_W];
	logic [31:0]        rad_s  [ROOT_W];
	logic [REM_W-1:0]   rem_s  [ROOT_W];
	logic [ROOT_W-1:0]  root_s [ROOT_W];
	logic signed [15:0] x_s    [ROOT_W];

	assign ysq = y * y;
	assign zsq = z * z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ysq_s1 <= $unsigned(ysq);
			zsq_s1 <= $unsigned(zsq);
			x_s1   <= x;
			sq_s2  <= ysq_s1 + zsq_s1;
			x_s2   <= x_s1;
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic               v_in;
		logic [31:0]        rad_in;
		logic [REM_W-1:0]   rem_in;
		logic [ROOT_W-1:0]  root_in;
		logic signed [15:0] x_in;
		logic [REM_W+1:0]   cur;
		logic [REM_W+1:0]   trial;
		logic [REM_W-1:0]   rem_nxt;
		logic [ROOT_W-1:0]  root_nxt;

		if (k == 0) begin : g_first
			assign v_in    = v_s2;
			assign rad_in  = sq_s2;
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = x_s2;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign x_in    = x_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		always_comb begin
			cur   = {rem_in, rad_in[31:30]};
			trial = {{(REM_W + 2 - ROOT_W - 2){1'b0}}, root_in, 2'b01};
			if (cur >= trial) begin
				rem_nxt  = REM_W'(cur - trial);
				root_nxt = {root_in[ROOT_W-2:0], 1'b1};
			end else begin
				rem_nxt  = cur[REM_W-1:0];
				root_nxt = {root_in[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_in[29:0], 2'b00};
				rem_s[k]  <= rem_nxt;
				root_s[k] <= root_nxt;
				x_s[k]    <= x_in;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign x_out     = x_s[ROOT_W-1];

endmodule

/* src/tilt_cordic.sv */
// vectoring cordic, one rotation per stage, angle in radians at 30 fraction bits
module tilt_cordic (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [tilt_pkg::ROOT_W-1:0] root,
	input  logic signed [15:0]          x,
	output logic                        out_valid,
	output tilt_pkg::ang_t              ang,
	output tilt_pkg::tilt_flag_t        flag
);
	import tilt_pkg::*;

	crd_t       xc_init;
	crd_t       yc_init;
	tilt_flag_t flag_init;

	logic       v_s    [ITER];
	crd_t       xc_s   [ITER];
	crd_t       yc_s   [ITER];
	ang_t       acc_s  [ITER];
	tilt_flag_t flag_s [ITER];

	assign xc_init = $signed({{(CRD_W - ROOT_W){1'b0}}, root});
	assign yc_init = $signed({{(CRD_W - 32){x[15]}}, x, 16'h0000});
	assign flag_init.zero_x = (x == 16'sd0);
	assign flag_init.zero_m = (root == '0);
	assign flag_init.neg_x  = x[15];

	for (genvar i = 0; i < ITER; i++) begin : g_rot
		logic       v_in;
		crd_t       xc_in;
		crd_t       yc_in;
		ang_t       acc_in;
		tilt_flag_t flag_in;
		crd_t       dx;
		crd_t       dy;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign xc_in   = xc_init;
			assign yc_in   = yc_init;
			assign acc_in  = '0;
			assign flag_in = flag_init;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign xc_in   = xc_s[i-1];
			assign yc_in   = yc_s[i-1];
			assign acc_in  = acc_s[i-1];
			assign flag_in = flag_s[i-1];
		end

		assign dx = yc_in >>> i;
		assign dy = xc_in >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		// drive y toward zero, a zero y rotates the negative way
		always_ff @(posedge clk) begin
			if (en) begin
				flag_s[i] <= flag_in;
				if (yc_in > 0) begin
					xc_s[i]  <= xc_in + dx;
					yc_s[i]  <= yc_in - dy;
					acc_s[i] <= acc_in + ATAN_TAB[i];
				end else begin
					xc_s[i]  <= xc_in - dx;
					yc_s[i]  <= yc_in + dy;
					acc_s[i] <= acc_in - ATAN_TAB[i];
				end
			end
		end
	end

	assign out_valid = v_s[ITER-1];
	assign ang       = acc_s[ITER-1];
	assign flag      = flag_s[ITER-1];

endmodule

/* src/tilt_scale.sv */
// radians to rounded hundredths of a degree, clamp and special cases
module tilt_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  tilt_pkg::ang_t                     ang,
	input  tilt_pkg::tilt_flag_t               flag,
	output logic                               out_valid,
	output logic signed [tilt_pkg::OUT_W-1:0]  tilt
);
	import tilt_pkg::*;

	logic                   v_s1;
	logic [ANG_W-2:0]       mag_s1;
	logic                   neg_s1;
	tilt_flag_t             flag_s1;
	logic                   v_s2;
	logic [ANG_W+30:0]      prod_s2;
	logic                   neg_s2;
	tilt_flag_t             flag_s2;
	logic                   v_s3;
	logic signed [OUT_W-1:0] tilt_s3;

	logic [63:0]            rnd;
	logic [OUT_W-1:0]       q;
	logic [OUT_W-1:0]       qc;
	logic signed [OUT_W-1:0] res;

	assign rnd = {1'b0, prod_s2} + (64'd1 << 48);
	assign q   = rnd[63:49];
	assign qc  = (q > RIGHT_ANGLE) ? RIGHT_ANGLE : q;

	always_comb begin
		if (flag_s2.zero_x) begin
			res = '0;
		end else if (flag_s2.zero_m) begin
			res = flag_s2.neg_x ? -$signed(RIGHT_ANGLE) : $signed(RIGHT_ANGLE);
		end else begin
			res = neg_s2 ? -$signed(qc) : $signed(qc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= ang[ANG_W-1] ? (ANG_W-1)'(-ang) : ang[ANG_W-2:0];
			neg_s1  <= ang[ANG_W-1];
			flag_s1 <= flag;
			prod_s2 <= mag_s1 * SCALE_C;
			neg_s2  <= neg_s1;
			flag_s2 <= flag_s1;
			tilt_s3 <= res;
		end
	end

	assign out_valid = v_s3;
	assign tilt      = tilt_s3;

endmodule

/* dv/tb_accel_tilt_angle.sv */
`timescale 1ns / 100ps
// self-checking testbench for the accelerometer tilt angle pipeline
module tb_accel_tilt_angle;

	import tilt_pkg::OUT_W;

	localparam int TILT_MAX   = 9000;
	localparam int STAGES     = 24;
	localparam int LATENCY    = 61;
	localparam int MAX_GAP    = 8;
	localparam int IDLE_PCT   = 32;
	localparam int N_RANDOM   = 1500;
	localparam int N_PROBES   = 20;
	localparam int CALM_FIRST = 700;
	localparam int CALM_LAST  = 999;
	localparam longint unsigned DEG_SCALE = 64'd3003948965;

	// atan(2^-i) in radians with 30 fraction bits
	localparam longint ATAN_RAD [STAGES] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};

	typedef struct {
		int x;
		int y;
		int z;
		bit typed;
		int want;
	} probe_t;

	// typed expectations only where the answer is plain: zero x, zero yz
	probe_t probes [N_PROBES] = '{
		'{0, 0, 0, 1, 0},
		'{32767, 0, 0, 1, 9000},
		'{-32768, 0, 0, 1, -9000},
		'{1, 0, 0, 1, 9000},
		'{-1, 0, 0, 1, -9000},
		'{0, 32767, -32768, 1, 0},
		'{0, -32768, 32767, 1, 0},
		'{0, 1, 0, 1, 0},
		'{32767, 32767, 32767, 0, 0},
		'{-32768, -32768, -32768, 0, 0},
		'{32767, -32768, -32768, 0, 0},
		'{-32768, 32767, 32767, 0, 0},
		'{1, 32767, 32767, 0, 0},
		'{-1, -32768, -32768, 0, 0},
		'{32767, 1, 0, 0, 0},
		'{-32768, 0, -1, 0, 0},
		'{100, 100, 0, 0, 0},
		'{-100, 0, -100, 0, 0},
		'{21845, -21846, 21845, 0, 0},
		'{-21846, 21845, -21846, 0, 0}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [15:0]      accel_x = '0;
	logic signed [15:0]      accel_y = '0;
	logic signed [15:0]      accel_z = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [OUT_W-1:0] tilt_hundredths;

	logic signed [OUT_W-1:0] pending_tilt [$];
	logic signed [OUT_W-1:0] tilt_want;
	bit                      calm = 1'b0;
	int                      errors = 0;
	int                      n_sent = 0;
	int                      n_checked = 0;
	int                      n_right = 0;

	accel_tilt_angle dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.accel_x         (accel_x),
		.accel_y         (accel_y),
		.accel_z         (accel_z),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.tilt_hundredths (tilt_hundredths)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("FAIL accel_tilt_angle");
		$finish;
	end

	// tilt in hundredths of a degree: root of y*y+z*z, vectoring cordic, scale, round and clamp
	function automatic logic signed [OUT_W-1:0] tilt_of_sample(
		input logic signed [15:0] x,
		input logic signed [15:0] y,
		input logic signed [15:0] z
	);
		longint xs, ys, zs, xc, yc, acc, dx, dy;
		longint unsigned rem, root, probe, mag, q;
		logic signed [OUT_W-1:0] r;
		xs = x;
		ys = y;
		zs = z;
		rem = ys * ys + zs * zs;
		rem = rem << 32;
		root = 0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		if (xs == 0)
			return '0;
		if (root == 0)
			return (xs > 0) ? OUT_W'(TILT_MAX) : -OUT_W'(TILT_MAX);
		xc = root;
		yc = xs * 65536;
		acc = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = yc >>> i;
			dy = xc >>> i;
			if (yc > 0) begin
				xc = xc + dx;
				yc = yc - dy;
				acc = acc + ATAN_RAD[i];
			end else begin
				xc = xc - dx;
				yc = yc + dy;
				acc = acc - ATAN_RAD[i];
			end
		end
		mag = (acc < 0) ? -acc : acc;
		q = (mag * DEG_SCALE + (64'd1 << 48)) >> 49;
		if (q > TILT_MAX)
			q = TILT_MAX;
		r = q[OUT_W-1:0];
		return (acc < 0) ? -r : r;
	endfunction

	// mostly full range, with zeros, extremes and small values mixed in
	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(9))
			0: return '0;
			1: begin
				case ($urandom_range(3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh0001;
					default: return 16'shffff;
				endcase
			end
			2, 3: return 16'($signed($urandom_range(127)) - 64);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_sample(
		input logic signed [15:0] x,
		input logic signed [15:0] y,
		input logic signed [15:0] z,
		input bit typed,
		input logic signed [OUT_W-1:0] want
	);
		int gap;
		gap = 0;
		if (!calm)
			while (gap < MAX_GAP && $urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		do
			@(posedge clk);
		while (in_stall);
		pending_tilt.push_back(typed ? want : tilt_of_sample(x, y, z));
		n_sent++;
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tilt.size() == 0) begin
				$error("tilt_hundredths: word with nothing expected, got %0d",
					tilt_hundredths);
				errors++;
			end else begin
				tilt_want = pending_tilt.pop_front();
				if (tilt_hundredths !== tilt_want) begin
					$error("tilt_hundredths: expected %0d, got %0d",
						tilt_want, tilt_hundredths);
					errors++;
				end
				if (tilt_want == TILT_MAX || tilt_want == -TILT_MAX)
					n_right++;
				n_checked++;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i])
			send_sample(16'(probes[i].x), 16'(probes[i].y), 16'(probes[i].z),
				probes[i].typed, OUT_W'(probes[i].want));

		for (int i = 0; i < N_RANDOM; i++) begin
			// a stretch where neither side idles
			calm = (i >= CALM_FIRST && i <= CALM_LAST);
			send_sample(rand_axis(), rand_axis(), rand_axis(), 1'b0, '0);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending_tilt.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("sent %0d samples (%0d directed), checked %0d angles, %0d at +-90 deg",
			n_sent, N_PROBES, n_checked, n_right);
		if (errors == 0)
			$display("PASS accel_tilt_angle");
		else
			$display("FAIL accel_tilt_angle");
		$finish;
	end

endmodule
